// ----- rtl/core/ssmt_pkg.sv -----
// shared constants, operation and status codes, and the cell control struct
// for the sorted triple table; no dependencies
package ssmt_pkg;

   localparam int INDEX_BITS        = 10;
   localparam int VALUE_BITS        = 32;
   localparam int KEY_BITS          = 2 * INDEX_BITS;
   localparam int CFG_BITS          = INDEX_BITS + 1;
   localparam int OPCODE_BITS       = 2;
   localparam int STATUS_BITS       = 2;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int DEF_TABLE_ENTRIES = 64;

   localparam logic [CFG_BITS-1:0] MAX_COLUMNS = CFG_BITS'(1 << INDEX_BITS);
   localparam logic [CFG_BITS-1:0] CFG_RESET   = CFG_BITS'(1 << INDEX_BITS);

   localparam logic [OPCODE_BITS-1:0] OP_READ    = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_MODIFY  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_SET_ROW = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_COUNT = 1'd1;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                  cmp;
      logic                  wr_hit;
      logic                  ins;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cell_ctl_type;

endpackage

// ----- rtl/core/ssmt_cell.sv -----
// one slot of the sorted triple chain: holds a key and value, compares against
// the broadcast key and shifts from its left neighbor on insert; uses ssmt_pkg
module ssmt_cell #(
   parameter int TABLE_ENTRIES = ssmt_pkg::DEF_TABLE_ENTRIES,
   parameter int SLOT          = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssmt_pkg::cell_ctl_type                 ctl,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     count,
   input  logic                                   left_gt,
   input  logic [ssmt_pkg::KEY_BITS-1:0]          left_key,
   input  logic [ssmt_pkg::VALUE_BITS-1:0]        left_value,
   output logic [ssmt_pkg::KEY_BITS-1:0]          key,
   output logic [ssmt_pkg::VALUE_BITS-1:0]        value,
   output logic                                   hit,
   output logic                                   gt,
   output logic [ssmt_pkg::VALUE_BITS-1:0]        sel_value
);
   import ssmt_pkg::*;

   localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] sel_ff, sel_in;
   logic                  hit_ff, hit_in;
   logic                  gt_ff, gt_in;
   logic                  slot_valid;
   logic                  slot_open;

   assign slot_valid = CNT_BITS'(SLOT) < count;
   // first free slot takes part in an insert as well
   assign slot_open  = CNT_BITS'(SLOT) == count;

   always_comb begin
      hit_in = hit_ff;
      gt_in  = gt_ff;
      sel_in = sel_ff;
      if (ctl.cmp) begin
         hit_in = slot_valid && (key_ff == ctl.key);
         gt_in  = slot_valid && (key_ff > ctl.key);
         sel_in = (slot_valid && (key_ff == ctl.key)) ? val_ff : '0;
      end
   end

   always_comb begin
      key_in = key_ff;
      val_in = val_ff;
      if (ctl.wr_hit && hit_ff) begin
         val_in = ctl.value;
      end else if (ctl.ins && (gt_ff || slot_open)) begin
         if (left_gt) begin
            key_in = left_key;
            val_in = left_value;
         end else begin
            key_in = ctl.key;
            val_in = ctl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         gt_ff  <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         gt_ff  <= gt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
      sel_ff <= sel_in;
   end

   assign key       = key_ff;
   assign value     = val_ff;
   assign hit       = hit_ff;
   assign gt        = gt_ff;
   assign sel_value = sel_ff;

endmodule

// ----- rtl/core/sparse_matrix_sorted_triple_table.sv -----
// Sparse matrix kept as a row-major sorted list of (row, column, value) triples
// in a chain of TABLE_ENTRIES cells. A read or modify passes through a range
// check in the accepting cycle, one compare pass over the chain, one apply pass
// (overwrite in place, or a one-step shift of the cells above the insert point)
// and the result register: the result is offered as the block returns to idle,
// where it takes the next transaction, so a new request waits until the last is
// through. A set-row makes a compare and an apply pass for each column below
// min(column_count, 1024) and stops early when an insert finds the table full;
// an index out of range skips the chain passes. A result still waiting for
// rsp_ready holds the block; depends on ssmt_pkg and ssmt_cell
module sparse_matrix_sorted_triple_table #(
   parameter int TABLE_ENTRIES = ssmt_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ssmt_pkg::OPCODE_BITS-1:0]       req_opcode,
   input  logic [ssmt_pkg::INDEX_BITS-1:0]        req_row_index,
   input  logic [ssmt_pkg::INDEX_BITS-1:0]        req_column_index,
   input  logic signed [ssmt_pkg::VALUE_BITS-1:0] req_new_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [31:0]                     rsp_prior_value,
   output logic [ssmt_pkg::STATUS_BITS-1:0]       rsp_status,
   input  logic                                   csr_write_enable,
   input  logic [ssmt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ssmt_pkg::CFG_BITS-1:0]          csr_write_data
);
   import ssmt_pkg::*;

   localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    entry_count_ff, entry_count_in;
   logic [CFG_BITS-1:0]    row_count_ff, row_count_in;
   logic [CFG_BITS-1:0]    column_count_ff, column_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     rsp_old_ff, rsp_old_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic [OPCODE_BITS-1:0] op_ff, op_in;
   logic [INDEX_BITS-1:0]  row_ff, row_in;
   logic [CFG_BITS-1:0]    col_ff, col_in;
   logic [CFG_BITS-1:0]    lim_ff, lim_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic signed [31:0]     res_old_ff, res_old_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;

   cell_ctl_type           ctl;
   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [TABLE_ENTRIES-1:0] gt_vec;
   logic [KEY_BITS-1:0]    key_arr [TABLE_ENTRIES];
   logic [VALUE_BITS-1:0]  val_arr [TABLE_ENTRIES];
   logic [VALUE_BITS-1:0]  sel_arr [TABLE_ENTRIES];
   logic [VALUE_BITS-1:0]  found_value;
   logic                   any_hit;
   logic                   table_full;
   logic                   is_write;
   logic                   req_fire;
   logic                   rsp_free;
   logic                   row_bad;
   logic                   col_bad;
   logic [CFG_BITS-1:0]    col_next;
   logic [CFG_BITS-1:0]    row_lim;

   genvar g;
   generate
      for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
         if (g == 0) begin : g_head
            ssmt_cell #(.TABLE_ENTRIES(TABLE_ENTRIES), .SLOT(g)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .count      (entry_count_ff),
               .left_gt    (1'b0),
               .left_key   ('0),
               .left_value ('0),
               .key        (key_arr[g]),
               .value      (val_arr[g]),
               .hit        (hit_vec[g]),
               .gt         (gt_vec[g]),
               .sel_value  (sel_arr[g])
            );
         end else begin : g_body
            ssmt_cell #(.TABLE_ENTRIES(TABLE_ENTRIES), .SLOT(g)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .count      (entry_count_ff),
               .left_gt    (gt_vec[g-1]),
               .left_key   (key_arr[g-1]),
               .left_value (val_arr[g-1]),
               .key        (key_arr[g]),
               .value      (val_arr[g]),
               .hit        (hit_vec[g]),
               .gt         (gt_vec[g]),
               .sel_value  (sel_arr[g])
            );
         end
      end
   endgenerate

   // at most one cell matches, so an or of the masked values picks it
   always_comb begin
      found_value = '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         found_value = found_value | sel_arr[k];
      end
   end

   assign any_hit    = |hit_vec;
   assign table_full = entry_count_ff >= CNT_BITS'(TABLE_ENTRIES);
   assign is_write   = (op_ff == OP_MODIFY) || (op_ff == OP_SET_ROW);
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign row_bad    = {1'b0, req_row_index} >= row_count_ff;
   assign col_bad    = {1'b0, req_column_index} >= column_count_ff;
   assign col_next   = col_ff + 1'b1;
   assign row_lim    = (column_count_ff > MAX_COLUMNS) ? MAX_COLUMNS : column_count_ff;

   always_comb begin
      ctl.cmp    = (state_ff == S_CMP);
      ctl.wr_hit = 1'b0;
      ctl.ins    = 1'b0;
      ctl.key    = {row_ff, col_ff[INDEX_BITS-1:0]};
      ctl.value  = val_ff;

      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      op_in          = op_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      lim_in         = lim_ff;
      val_in         = val_ff;
      res_old_in     = res_old_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_old_in     = rsp_old_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_opcode;
               row_in        = req_row_index;
               col_in        = {1'b0, req_column_index};
               val_in        = req_new_value;
               lim_in        = row_lim;
               res_old_in    = '0;
               res_status_in = ST_OK;
               priority if (req_opcode == OP_SET_ROW) begin
                  col_in = '0;
                  if (row_bad) begin
                     res_status_in = ST_RANGE;
                     state_in      = S_DONE;
                  end else if (row_lim == '0) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_CMP;
                  end
               end else if (row_bad || col_bad) begin
                  res_status_in = ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_DONE;
            priority if (!is_write) begin
               res_old_in = $signed(found_value);
            end else if (any_hit) begin
               ctl.wr_hit = 1'b1;
               if (op_ff == OP_MODIFY) begin
                  res_old_in = $signed(found_value);
               end
            end else if (table_full) begin
               res_status_in = ST_FULL;
            end else begin
               ctl.ins        = 1'b1;
               entry_count_in = entry_count_ff + 1'b1;
            end
            // set row walks on to the next column below the limit unless the table filled up
            if (op_ff == OP_SET_ROW && (any_hit || !table_full) && col_next < lim_ff) begin
               col_in   = col_next;
               state_in = S_CMP;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_old_in    = res_old_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_in    = csr_write_data;
            CSR_COLUMN_COUNT: column_count_in = csr_write_data;
            default:          row_count_in    = row_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         entry_count_ff  <= '0;
         row_count_ff    <= CFG_RESET;
         column_count_ff <= CFG_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         entry_count_ff  <= entry_count_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      lim_ff        <= lim_in;
      val_ff        <= val_in;
      res_old_ff    <= res_old_in;
      res_status_ff <= res_status_in;
      rsp_old_ff    <= rsp_old_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prior_value = rsp_old_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_BITS'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |-> $onehot0(hit_vec))
      else $error("position stored in more than one cell");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && ctl.ins) |=>
         entry_count_ff == CNT_BITS'($past(entry_count_ff) + 1'b1))
      else $error("insert did not grow the table by one");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |-> !table_full && !any_hit)
      else $error("insert into full table or over an existing position");
`endif

endmodule
